[rtl/sdf_pkg.sv]
// ---------------------------------------------------------------------------
// sdf_pkg
// Shared types and constants of the sequence duplicate filter.
// ---------------------------------------------------------------------------
`default_nettype none

package sdf_pkg;

	// Fixed widths of the packet fields at the block boundary.
	localparam int unsigned SRC_KEY_BITS = 64;
	localparam int unsigned SEQ_BITS     = 32;

	typedef logic [1:0] outcome_t;

	// Outcome codes reported for each packet.
	localparam outcome_t OUT_DUPLICATE = 2'd0;
	localparam outcome_t OUT_UPDATED   = 2'd1;
	localparam outcome_t OUT_STORED    = 2'd2;
	localparam outcome_t OUT_FULL      = 2'd3;

	// Finished result offered by the scan engine to the output register.
	typedef struct packed {
		logic     vld;
		outcome_t outcome;
	} sdf_res_t;

endpackage

`default_nettype wire

[rtl/sdf_pkt_if.sv]
// ---------------------------------------------------------------------------
// sdf_pkt_if
// Packet channel: valid/ready handshake with source key and sequence number.
// ---------------------------------------------------------------------------
`default_nettype none

interface sdf_pkt_if;
	logic                               valid;
	logic                               ready;
	logic [sdf_pkg::SRC_KEY_BITS-1:0]   source_key;
	logic [sdf_pkg::SEQ_BITS-1:0]       seq_number;

	modport source (output valid, output source_key, output seq_number, input ready);
	modport sink   (input valid, input source_key, input seq_number, output ready);
endinterface

`default_nettype wire

[rtl/sdf_res_if.sv]
// ---------------------------------------------------------------------------
// sdf_res_if
// Result channel: valid/ready handshake with the packet outcome.
// ---------------------------------------------------------------------------
`default_nettype none

interface sdf_res_if;
	logic                valid;
	logic                ready;
	sdf_pkg::outcome_t   outcome;

	modport source (output valid, output outcome, input ready);
	modport sink   (input valid, input outcome, output ready);
endinterface

`default_nettype wire

[rtl/sdf_ram.sv]
// ---------------------------------------------------------------------------
// sdf_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module sdf_ram #(
	parameter int unsigned WIDTH = 96,
	parameter int unsigned DEPTH = 16,
	localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             rd_en,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[rtl/sdf_scan.sv]
// ---------------------------------------------------------------------------
// sdf_scan
// Scan engine: walks the stored entries through the RAM, compares keys and
// sequence numbers, and writes back an update or a new entry if one is due.
// ---------------------------------------------------------------------------
`default_nettype none

module sdf_scan #(
	parameter int unsigned TABLE_ENTRIES = 16,
	parameter int unsigned KEY_BITS      = 64,
	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
	localparam int unsigned RW = KEY_BITS + sdf_pkg::SEQ_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	sdf_pkt_if.sink                pkt,
	// RAM access
	output logic                   ram_wr_en,
	output logic [AW-1:0]          ram_wr_addr,
	output logic [RW-1:0]          ram_wr_data,
	output logic                   ram_rd_en,
	output logic [AW-1:0]          ram_rd_addr,
	input  wire logic [RW-1:0]     ram_rd_data,
	// Finished result and its acceptance by the output register
	output sdf_pkg::sdf_res_t      res,
	input  wire logic              res_take
);

	import sdf_pkg::*;

	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_SCAN   = 2'd1;
	localparam logic [1:0] ST_RESULT = 2'd2;

	logic [1:0]          state_q;
	logic [CW-1:0]       count_q;
	logic [CW-1:0]       idx_q;
	logic                cmp_vld_s1;
	logic [AW-1:0]       cmp_idx_s1;
	logic [KEY_BITS-1:0] key_q;
	logic [SEQ_BITS-1:0] seq_q;
	outcome_t            outcome_q;

	logic                issue;
	logic                hit;
	logic                newer;
	logic                miss_done;
	logic                has_free;
	logic [KEY_BITS-1:0] rd_key;
	logic [SEQ_BITS-1:0] rd_seq;

	// Valid entries always form a prefix of the table, so the fill count
	// stands in for the per-entry valid marks.
	assign rd_key    = ram_rd_data[RW-1 -: KEY_BITS];
	assign rd_seq    = ram_rd_data[SEQ_BITS-1:0];
	assign issue     = (state_q == ST_SCAN) && (idx_q < count_q);
	assign hit       = cmp_vld_s1 && (rd_key == key_q);
	assign newer     = seq_q > rd_seq;
	assign miss_done = (state_q == ST_SCAN) && (idx_q == count_q) && !hit;
	assign has_free  = count_q < CW'(TABLE_ENTRIES);

	// RAM ports: one read per cycle while scanning, at most one write at the end.
	assign ram_rd_en   = issue;
	assign ram_rd_addr = idx_q[AW-1:0];
	assign ram_wr_en   = (hit && newer) || (miss_done && has_free);
	assign ram_wr_addr = hit ? cmp_idx_s1 : count_q[AW-1:0];
	assign ram_wr_data = {key_q, seq_q};

	assign pkt.ready   = (state_q == ST_IDLE);
	assign res.vld     = (state_q == ST_RESULT);
	assign res.outcome = outcome_q;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			idx_q      <= '0;
			cmp_vld_s1 <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					cmp_vld_s1 <= 1'b0;
					if (pkt.valid) begin
						idx_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					cmp_vld_s1 <= issue && !hit && !miss_done;
					if (issue) begin
						idx_q <= idx_q + 1'b1;
					end
					if (hit) begin
						state_q <= ST_RESULT;
					end else if (miss_done) begin
						if (has_free) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_RESULT;
					end
				end
				ST_RESULT: begin
					cmp_vld_s1 <= 1'b0;
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					cmp_vld_s1 <= 1'b0;
				end
			endcase
		end
	end

	// Packet payload, compare index and outcome.
	always_ff @(posedge clk) begin
		if (pkt.valid && pkt.ready) begin
			key_q <= pkt.source_key[KEY_BITS-1:0];
			seq_q <= pkt.seq_number;
		end
		cmp_idx_s1 <= idx_q[AW-1:0];
		if (hit) begin
			outcome_q <= newer ? OUT_UPDATED : OUT_DUPLICATE;
		end else if (miss_done) begin
			outcome_q <= has_free ? OUT_STORED : OUT_FULL;
		end
	end

endmodule

`default_nettype wire

[rtl/sequence_duplicate_filter_core.sv]
// ---------------------------------------------------------------------------
// sequence_duplicate_filter_core
// Per-source duplicate filter for received packets keyed by source and
// sequence number.
// ---------------------------------------------------------------------------
// The scan reads one stored entry per cycle through the single read port of the
// entry RAM, starting at entry 0, and stops at the first key match; a packet
// from an unknown source is compared with every filled entry. One packet is
// worked on at a time; the next is accepted once the result has moved into the
// output register, even while that register still waits to be taken.
// Table occupancy is a fill count cleared by reset, so there is no clearing
// pass after reset. Only the low KEY_BITS bits of source_key are stored and
// matched.
`default_nettype none

module sequence_duplicate_filter_core #(
	parameter int unsigned TABLE_ENTRIES = 16,
	parameter int unsigned KEY_BITS      = 64
) (
	input  wire logic clk,
	input  wire logic arst_n,
	sdf_pkt_if.sink   pkt,
	sdf_res_if.source res
);

	import sdf_pkg::*;

	localparam int unsigned AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int unsigned RW = KEY_BITS + SEQ_BITS;

	logic          ram_wr_en;
	logic [AW-1:0] ram_wr_addr;
	logic [RW-1:0] ram_wr_data;
	logic          ram_rd_en;
	logic [AW-1:0] ram_rd_addr;
	logic [RW-1:0] ram_rd_data;
	sdf_res_t      scan_res;
	logic          res_take;
	logic          out_vld_q;
	outcome_t      out_outcome_q;

	// Entry store: key and last sequence number per source.
	sdf_ram #(
		.WIDTH (RW),
		.DEPTH (TABLE_ENTRIES)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (ram_rd_addr),
		.rd_data (ram_rd_data)
	);

	sdf_scan #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.KEY_BITS      (KEY_BITS)
	) u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.pkt         (pkt),
		.ram_wr_en   (ram_wr_en),
		.ram_wr_addr (ram_wr_addr),
		.ram_wr_data (ram_wr_data),
		.ram_rd_en   (ram_rd_en),
		.ram_rd_addr (ram_rd_addr),
		.ram_rd_data (ram_rd_data),
		.res         (scan_res),
		.res_take    (res_take)
	);

	// Output register: takes a finished result when empty or being drained.
	assign res_take    = !out_vld_q || res.ready;
	assign res.valid   = out_vld_q;
	assign res.outcome = out_outcome_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (res_take) begin
			out_vld_q <= scan_res.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && scan_res.vld) begin
			out_outcome_q <= scan_res.outcome;
		end
	end

endmodule

`default_nettype wire

[rtl/sdf_checker.sv]
// ---------------------------------------------------------------------------
// sdf_checker
// Port-level checks of the duplicate filter, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module sdf_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              pkt_valid,
	input wire logic              pkt_ready,
	input wire logic              res_valid,
	input wire logic              res_ready,
	input wire sdf_pkg::outcome_t res_outcome
);

	logic       pkt_acc;
	logic       res_acc;
	logic [1:0] pend_q;

	assign pkt_acc = pkt_valid && pkt_ready;
	assign res_acc = res_valid && res_ready;

	// Packets accepted whose result has not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
		end else begin
			pend_q <= pend_q + {1'b0, pkt_acc} - {1'b0, res_acc};
		end
	end

	// A waiting result holds its outcome until taken.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_outcome))
		else $error("result changed while stalled");

	// One packet is scanned at a time.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_acc |=> !pkt_ready)
		else $error("packet accepted during a scan");

	// No result is offered without an accepted packet behind it.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pend_q != 2'd0)
		else $error("result without a packet");

	// At most one result waits while one packet is being scanned.
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many packets outstanding");

endmodule

bind sequence_duplicate_filter_core sdf_checker u_sdf_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.pkt_valid   (pkt.valid),
	.pkt_ready   (pkt.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.res_outcome (res.outcome)
);

`default_nettype wire
